@@ sv/swfr_pkg.sv @@
// Shared constants and types of the stop-and-wait frame receiver.
package swfr_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_MASK  = 8'h20;
  localparam logic [7:0] CTRL_RR   = 8'h05;
  localparam logic [7:0] CTRL_REJ  = 8'h01;

  // Default frame length limit, both flags included
  localparam int DEF_MAX_FRAME_BYTES = 1024;

  // Reset value of the own address register
  localparam logic [7:0] OWN_ADDR_RESET = 8'h01;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_DUP      = 3'd2,
    KIND_BCC1     = 3'd3,
    KIND_BCC2     = 3'd4,
    KIND_CTRL     = 3'd5,
    KIND_OVERFLOW = 3'd6
  } kind_t;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       respond;
    logic [7:0] rsp_ctrl;
    logic [7:0] rsp_check;
    logic       frame_seq;
  } result_t;

endpackage

@@ sv/swfr_ifs.sv @@
// Valid/ready channel interfaces for line bytes and for results.
interface swfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] data_byte;
  logic       respond;
  logic [7:0] response_control;
  logic [7:0] response_check;
  logic       frame_seq;

  modport source (
    output valid, output result_kind, output data_byte, output respond,
    output response_control, output response_check, output frame_seq,
    input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input respond,
    input response_control, input response_check, input frame_seq,
    output ready
  );
endinterface

@@ sv/swfr_core.sv @@
// Frame state and per-byte decode: delimiting, header check, destuffing, verdicts.
module swfr_core #(
  parameter int MAX_FRAME_BYTES = swfr_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        own_addr_i,
  output logic              res_vld_o,
  output swfr_pkg::result_t res_o
);
  import swfr_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);
  // byte count at which the next non-flag byte overflows the frame
  localparam logic [IDX_W-1:0] OVF_AT = IDX_W'(MAX_FRAME_BYTES - 2);

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_INSEQ = 2'd1,
    CLS_DUP   = 2'd2,
    CLS_CTRL  = 2'd3
  } fclass_t;

  logic             in_frame_r, in_frame_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       hdr_addr_r, hdr_addr_nxt;
  logic [7:0]       hdr_ctrl_r, hdr_ctrl_nxt;
  fclass_t          class_r, class_nxt;
  logic             esc_r, esc_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic             exp_seq_r, exp_seq_nxt;

  // Next state and result for one byte
  always_comb begin
    logic [IDX_W-1:0] idx_inc;
    logic [7:0]       d;
    logic             d_vld;
    logic [7:0]       ctl;

    in_frame_nxt = in_frame_r;
    idx_nxt      = idx_r;
    hdr_addr_nxt = hdr_addr_r;
    hdr_ctrl_nxt = hdr_ctrl_r;
    class_nxt    = class_r;
    esc_nxt      = esc_r;
    xor_nxt      = xor_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    exp_seq_nxt  = exp_seq_r;
    res_vld_o    = 1'b0;
    res_o        = '0;
    res_o.kind   = KIND_DATA;
    idx_inc      = idx_r + IDX_W'(1);
    d            = byte_i;
    d_vld        = 1'b0;
    ctl          = 8'h00;

    if (step_i) begin
      if (!in_frame_r) begin
        // hunt for an opening flag
        if (byte_i == FLAG_BYTE) begin
          in_frame_nxt = 1'b1;
          idx_nxt      = '0;
          hdr_addr_nxt = 8'h00;
          hdr_ctrl_nxt = 8'h00;
          class_nxt    = CLS_NONE;
          esc_nxt      = 1'b0;
          xor_nxt      = 8'h00;
          held_nxt     = 8'h00;
          held_vld_nxt = 1'b0;
        end
      end else if (byte_i == FLAG_BYTE) begin
        // closing flag; a flag right after the opener is a fresh opener
        if (idx_r != '0) begin
          in_frame_nxt = 1'b0;
          esc_nxt      = 1'b0;
          res_vld_o    = 1'b1;
          unique case (class_r)
            CLS_NONE: begin
              res_o.kind    = KIND_BCC1;
              res_o.respond = 1'b1;
              ctl           = {1'b0, exp_seq_r, 6'b0} ^ CTRL_REJ;
            end
            CLS_CTRL: begin
              res_o.kind = KIND_CTRL;
              res_o.data = hdr_ctrl_r;
            end
            CLS_DUP: begin
              res_o.kind      = KIND_DUP;
              res_o.respond   = 1'b1;
              res_o.frame_seq = hdr_ctrl_r[6];
              ctl             = {1'b0, exp_seq_r, 6'b0} ^ CTRL_RR;
            end
            CLS_INSEQ: begin
              res_o.respond   = 1'b1;
              res_o.frame_seq = hdr_ctrl_r[6];
              held_vld_nxt    = 1'b0;
              if (held_vld_r && (held_r == xor_r)) begin
                res_o.kind  = KIND_ACCEPT;
                exp_seq_nxt = ~exp_seq_r;
                ctl         = {1'b0, ~exp_seq_r, 6'b0} ^ CTRL_RR;
              end else begin
                res_o.kind = KIND_BCC2;
                ctl        = {1'b0, exp_seq_r, 6'b0} ^ CTRL_REJ;
              end
            end
            default: ;
          endcase
          res_o.rsp_ctrl  = ctl;
          res_o.rsp_check = res_o.respond ? (own_addr_i ^ ctl) : 8'h00;
        end
      end else if (idx_r >= OVF_AT) begin
        // length limit: drop the frame
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        held_vld_nxt = 1'b0;
        res_vld_o    = 1'b1;
        res_o.kind   = KIND_OVERFLOW;
      end else begin
        idx_nxt = idx_inc;
        if (idx_inc == IDX_W'(1)) begin
          hdr_addr_nxt = byte_i;
        end else if (idx_inc == IDX_W'(2)) begin
          hdr_ctrl_nxt = byte_i;
        end else if (idx_inc == IDX_W'(3)) begin
          // header check and classification
          if ((hdr_addr_r ^ hdr_ctrl_r) != byte_i) begin
            class_nxt = CLS_NONE;
          end else if (hdr_ctrl_r[0]) begin
            class_nxt = CLS_CTRL;
          end else if (hdr_ctrl_r[7:6] == {1'b0, exp_seq_r}) begin
            class_nxt = CLS_INSEQ;
          end else begin
            class_nxt = CLS_DUP;
          end
        end else if (class_r == CLS_INSEQ) begin
          // destuff
          if (esc_r) begin
            d       = byte_i ^ ESC_MASK;
            d_vld   = 1'b1;
            esc_nxt = 1'b0;
          end else if (byte_i == ESC_BYTE) begin
            esc_nxt = 1'b1;
          end else begin
            d_vld = 1'b1;
          end
          // one-byte delay: the last byte is kept as the BCC2 candidate
          if (d_vld) begin
            held_nxt     = d;
            held_vld_nxt = 1'b1;
            if (held_vld_r) begin
              xor_nxt         = xor_r ^ held_r;
              res_vld_o       = 1'b1;
              res_o.kind      = KIND_DATA;
              res_o.data      = held_r;
              res_o.frame_seq = hdr_ctrl_r[6];
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r      <= '0;
      hdr_addr_r <= 8'h00;
      hdr_ctrl_r <= 8'h00;
      class_r    <= CLS_NONE;
      esc_r      <= 1'b0;
      xor_r      <= 8'h00;
      held_r     <= 8'h00;
      held_vld_r <= 1'b0;
      exp_seq_r  <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
      hdr_addr_r <= hdr_addr_nxt;
      hdr_ctrl_r <= hdr_ctrl_nxt;
      class_r    <= class_nxt;
      esc_r      <= esc_nxt;
      xor_r      <= xor_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      exp_seq_r  <= exp_seq_nxt;
    end
  end

endmodule

@@ sv/stop_and_wait_frame_receiver.sv @@
// Top level of the stop-and-wait frame receiver.
//
// Usage:
//   in_ch  : one raw line byte per word (valid/ready). Flag 0x7E delimits
//            frames; address, control and BCC1 follow, then for information
//            frames the byte-stuffed payload and BCC2.
//   out_ch : result words (valid/ready): delayed payload bytes, one verdict
//            per closed frame (accepted, duplicate, bcc1/bcc2 error, control
//            frame) with the RR/REJ response fields where due, or an overflow word.
//   cfg_we/cfg_wdata : own address used in response checks; write only
//            while the block is idle.
// Path: a byte accepted lands in the input register; its decode result is
//   registered into the result register once that register is free or being drained.
// Throughput: one byte per cycle; the per-byte decode is a single registered
//   pass, and the input register keeps taking bytes as long as the result
//   register is empty or taken in the same cycle.
// Reset: frame state cleared, expected sequence bit 0, own address 1.
// Stall: when out_ch.ready is low with a result held, the input register
//   fills and in_ch.ready drops until the result word is taken.
module stop_and_wait_frame_receiver #(
  parameter int MAX_FRAME_BYTES = swfr_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic            clk,
  input  logic            rst_n,
  swfr_in_if.sink         in_ch,
  swfr_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);
  import swfr_pkg::*;

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       adv;
  logic       out_vld_r;
  result_t    out_res_r;
  logic [7:0] own_addr_r;
  logic       res_vld;
  result_t    res;

  // Decode advances when the output register is free or being drained
  assign adv          = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || adv;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RESET;
    end else if (cfg_we) begin
      own_addr_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  swfr_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (adv),
    .byte_i     (s1_byte_r),
    .own_addr_i (own_addr_r),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.result_kind      = out_res_r.kind;
  assign out_ch.data_byte        = out_res_r.data;
  assign out_ch.respond          = out_res_r.respond;
  assign out_ch.response_control = out_res_r.rsp_ctrl;
  assign out_ch.response_check   = out_res_r.rsp_check;
  assign out_ch.frame_seq        = out_res_r.frame_seq;

  // Only verdicts that answer the sender carry a response
  a_respond_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.respond) |->
      (out_res_r.kind == KIND_ACCEPT || out_res_r.kind == KIND_DUP ||
       out_res_r.kind == KIND_BCC1 || out_res_r.kind == KIND_BCC2))
    else $error("response on a non-verdict result");

  // An accepted frame asks for the opposite sequence bit
  a_accept_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind == KIND_ACCEPT) |->
      (out_res_r.rsp_ctrl[6] != out_res_r.frame_seq))
    else $error("accept does not advance the sequence bit");

  // Data byte is zero except for payload and control results
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.kind != KIND_DATA && out_res_r.kind != KIND_CTRL) |->
      (out_res_r.data == 8'h00))
    else $error("stray data byte on a verdict");

  // Input backpressure only when both registers are full and the sink stalls
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_vld_r && out_vld_r && !out_ch.ready))
    else $error("input stalled without cause");

endmodule

@@ tb/tb.sv @@
// Testbench for the stop-and-wait frame receiver: directed and random line traffic.
module tb;
  import swfr_pkg::*;

  localparam int FRAME_LIMIT    = DEF_MAX_FRAME_BYTES;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_LIMIT    = 100000;
  localparam int RANDOM_BYTES   = 300;
  localparam int CFG_INTERVAL   = 100;
  localparam longint WATCHDOG_TIME = 64'd40_000_000;

  // Header classification kept by the model
  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_INSEQ,
    HDR_DUP,
    HDR_CTRL
  } hdr_class_t;

  // How an information frame ends
  typedef enum logic [1:0] {
    TAIL_GOOD,
    TAIL_BAD,
    TAIL_NONE,
    TAIL_OPEN_ESC
  } tail_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  swfr_in_if  in_ch ();
  swfr_out_if out_ch ();

  stop_and_wait_frame_receiver #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hang guard
  initial begin
    #(WATCHDOG_TIME);
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver model state
  logic [7:0] own_addr;
  logic       rx_open;
  int         rx_count;
  logic [7:0] hdr_addr;
  logic [7:0] hdr_ctrl;
  hdr_class_t rx_class;
  logic       esc_armed;
  logic [7:0] data_xor;
  logic [7:0] delay_byte;
  logic       delay_full;
  logic       seq_expect;

  result_t    awaited_words[$];
  logic [7:0] line_q[$];

  int         error_count = 0;
  int         sent_bytes  = 0;
  int         burst_left  = 0;
  int         kind_seen[8];
  logic [9:0] stall_cycle = '0;

  function automatic void reset_model();
    own_addr   = OWN_ADDR_RESET;
    rx_open    = 1'b0;
    rx_count   = 0;
    hdr_addr   = 8'h00;
    hdr_ctrl   = 8'h00;
    rx_class   = HDR_NONE;
    esc_armed  = 1'b0;
    data_xor   = 8'h00;
    delay_byte = 8'h00;
    delay_full = 1'b0;
    seq_expect = 1'b0;
  endfunction

  function automatic void push_word(kind_t k, logic [7:0] data, logic respond,
                                    logic [7:0] ctrl, logic seq);
    result_t w;
    w.kind      = k;
    w.data      = data;
    w.respond   = respond;
    w.rsp_ctrl  = respond ? ctrl : 8'h00;
    w.rsp_check = respond ? (own_addr ^ ctrl) : 8'h00;
    w.frame_seq = seq;
    awaited_words.push_back(w);
  endfunction

  // RR/REJ byte carrying the current expected bit in bit 6
  function automatic logic [7:0] answer(logic [7:0] code);
    return {1'b0, seq_expect, 6'b0} ^ code;
  endfunction

  function automatic void open_frame();
    rx_open    = 1'b1;
    rx_count   = 0;
    hdr_addr   = 8'h00;
    hdr_ctrl   = 8'h00;
    rx_class   = HDR_NONE;
    esc_armed  = 1'b0;
    data_xor   = 8'h00;
    delay_byte = 8'h00;
    delay_full = 1'b0;
  endfunction

  // Verdict on the closing flag
  function automatic void close_frame();
    rx_open   = 1'b0;
    esc_armed = 1'b0;
    if (rx_count < 3 || rx_class == HDR_NONE) begin
      push_word(KIND_BCC1, 8'h00, 1'b1, answer(CTRL_REJ), 1'b0);
    end else if (rx_class == HDR_CTRL) begin
      push_word(KIND_CTRL, hdr_ctrl, 1'b0, 8'h00, 1'b0);
    end else if (rx_class == HDR_DUP) begin
      push_word(KIND_DUP, 8'h00, 1'b1, answer(CTRL_RR), hdr_ctrl[6]);
    end else begin
      if (delay_full && delay_byte == data_xor) begin
        seq_expect = ~seq_expect;
        push_word(KIND_ACCEPT, 8'h00, 1'b1, answer(CTRL_RR), hdr_ctrl[6]);
      end else begin
        push_word(KIND_BCC2, 8'h00, 1'b1, answer(CTRL_REJ), hdr_ctrl[6]);
      end
      delay_full = 1'b0;
    end
  endfunction

  // Expected result words caused by one accepted line byte
  function automatic void decode_line_byte(logic [7:0] b);
    logic [7:0] d;
    if (!rx_open) begin
      if (b == FLAG_BYTE) open_frame();
      return;
    end
    if (b == FLAG_BYTE) begin
      // flag right after the opening flag: fresh frame, no verdict
      if (rx_count != 0) close_frame();
      return;
    end
    rx_count++;
    if (rx_count + 1 >= FRAME_LIMIT) begin
      rx_open    = 1'b0;
      esc_armed  = 1'b0;
      delay_full = 1'b0;
      push_word(KIND_OVERFLOW, 8'h00, 1'b0, 8'h00, 1'b0);
      return;
    end
    if (rx_count == 1) begin
      hdr_addr = b;
      return;
    end
    if (rx_count == 2) begin
      hdr_ctrl = b;
      return;
    end
    if (rx_count == 3) begin
      if ((hdr_addr ^ hdr_ctrl) != b) rx_class = HDR_NONE;
      else if (hdr_ctrl[0]) rx_class = HDR_CTRL;
      else if (hdr_ctrl[7:6] == {1'b0, seq_expect}) rx_class = HDR_INSEQ;
      else rx_class = HDR_DUP;
      return;
    end
    if (rx_class != HDR_INSEQ) return;
    if (esc_armed) begin
      d = b ^ ESC_MASK;
      esc_armed = 1'b0;
    end else if (b == ESC_BYTE) begin
      esc_armed = 1'b1;
      return;
    end else begin
      d = b;
    end
    // payload goes out one word late; the last one is the BCC2 candidate
    if (delay_full) begin
      data_xor ^= delay_byte;
      push_word(KIND_DATA, delay_byte, 1'b0, 8'h00, hdr_ctrl[6]);
      delay_byte = d;
    end else begin
      delay_byte = d;
      delay_full = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %02h, actual %02h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (awaited_words.size() == 0) begin
      $error("unexpected result word: kind %0d data %02h",
             out_ch.result_kind, out_ch.data_byte);
      error_count++;
      return;
    end
    want = awaited_words.pop_front();
    kind_seen[out_ch.result_kind]++;
    check_field("result_kind", want.kind, out_ch.result_kind);
    check_field("data_byte", want.data, out_ch.data_byte);
    check_field("respond", want.respond, out_ch.respond);
    check_field("response_control", want.rsp_ctrl, out_ch.response_control);
    check_field("response_check", want.rsp_check, out_ch.response_check);
    check_field("frame_seq", want.frame_seq, out_ch.frame_seq);
  endfunction

  // Result side: check on handshake, stall in four phases set by the top counter bits
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) check_result();
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[9:8])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= $urandom_range(0, 1);
      2'd2: out_ch.ready <= (stall_cycle[1:0] == 2'd0);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // One line word, sent in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    burst_left--;
    sent_bytes++;
    decode_line_byte(b);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    while (awaited_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_words.size() != 0) begin
      $error("%0d expected result words never arrived", awaited_words.size());
      error_count++;
      awaited_words.delete();
    end
  endtask

  // Register write with the block idle
  task automatic set_own_address(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    own_addr = v;
  endtask

  // Frame building
  function automatic logic [7:0] pick_payload_byte();
    case ($urandom_range(0, 5))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_stuffed(logic [7:0] v);
    // flag and escape must be stuffed; other bytes sometimes are
    if (v == FLAG_BYTE || v == ESC_BYTE ||
        ((v ^ ESC_MASK) != FLAG_BYTE && $urandom_range(0, 15) == 0)) begin
      line_q.push_back(ESC_BYTE);
      line_q.push_back(v ^ ESC_MASK);
    end else begin
      line_q.push_back(v);
    end
  endfunction

  function automatic void push_noise(int n);
    logic [7:0] v;
    repeat (n) begin
      do v = 8'($urandom_range(0, 255)); while (v == FLAG_BYTE);
      line_q.push_back(v);
    end
  endfunction

  function automatic logic [7:0] pick_ctrl(hdr_class_t cls);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
      case (cls)
        HDR_INSEQ: c = {1'b0, seq_expect, c[5:1], 1'b0};
        HDR_DUP: begin
          c[0] = 1'b0;
          if (c[7:6] == {1'b0, seq_expect}) c[7] = 1'b1;
        end
        default: c[0] = 1'b1;
      endcase
    end while (c == FLAG_BYTE);
    return c;
  endfunction

  function automatic logic [7:0] pick_addr(logic [7:0] c);
    logic [7:0] a;
    do a = 8'($urandom_range(0, 255)); while (a == FLAG_BYTE || (a ^ c) == FLAG_BYTE);
    return a;
  endfunction

  function automatic void build_frame(hdr_class_t cls, int len, tail_t tail,
                                      logic bad_hdr, int reps);
    logic [7:0] a, c, chk, x, v, flip;
    c   = pick_ctrl(cls);
    a   = pick_addr(c);
    chk = a ^ c;
    if (bad_hdr) begin
      do flip = 8'($urandom_range(1, 255)); while ((chk ^ flip) == FLAG_BYTE);
      chk ^= flip;
    end
    line_q.push_back(FLAG_BYTE);
    repeat (reps) line_q.push_back(FLAG_BYTE);
    line_q.push_back(a);
    line_q.push_back(c);
    line_q.push_back(chk);
    x = 8'h00;
    for (int i = 0; i < len; i++) begin
      v = pick_payload_byte();
      x ^= v;
      push_stuffed(v);
    end
    case (tail)
      TAIL_GOOD: push_stuffed(x);
      TAIL_BAD: push_stuffed(x ^ 8'($urandom_range(1, 255)));
      TAIL_OPEN_ESC: begin
        push_stuffed(x);
        line_q.push_back(ESC_BYTE);
      end
      default: ;
    endcase
    line_q.push_back(FLAG_BYTE);
  endfunction

  // Frame with a fixed count of bytes after the opening flag, no stuffing needed
  function automatic void build_long_frame(hdr_class_t cls, int body, logic closed);
    logic [7:0] a, c, x, v;
    c = pick_ctrl(cls);
    a = pick_addr(c);
    line_q.push_back(FLAG_BYTE);
    line_q.push_back(a);
    line_q.push_back(c);
    line_q.push_back(a ^ c);
    x = 8'h00;
    for (int i = 0; i < body - 4; i++) begin
      v = 8'($urandom_range(0, 63));
      x ^= v;
      line_q.push_back(v);
    end
    line_q.push_back(x);
    if (closed) line_q.push_back(FLAG_BYTE);
  endfunction

  function automatic void random_frame();
    int pick, len, reps;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
    reps = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
    if ($urandom_range(0, 7) == 0) push_noise($urandom_range(1, 3));
    if (pick < 55) begin
      build_frame(HDR_INSEQ, len, TAIL_GOOD, 1'b0, reps);
    end else if (pick < 63) begin
      build_frame(HDR_DUP, len, TAIL_GOOD, 1'b0, reps);
    end else if (pick < 69) begin
      build_frame(HDR_INSEQ, len, TAIL_BAD, 1'b0, reps);
    end else if (pick < 74) begin
      build_frame(HDR_INSEQ, len, TAIL_GOOD, 1'b1, reps);
    end else if (pick < 80) begin
      build_frame(HDR_CTRL, len, TAIL_GOOD, 1'b0, reps);
    end else if (pick < 85) begin
      // frame closed before its header check arrived
      line_q.push_back(FLAG_BYTE);
      repeat (reps) line_q.push_back(FLAG_BYTE);
      push_noise($urandom_range(0, 2));
      line_q.push_back(FLAG_BYTE);
    end else if (pick < 89) begin
      build_frame(HDR_INSEQ, 0, TAIL_NONE, 1'b0, reps);
    end else if (pick < 93) begin
      build_frame(HDR_INSEQ, len, TAIL_OPEN_ESC, 1'b0, reps);
    end else begin
      // raw line garbage, flags included
      line_q.push_back(FLAG_BYTE);
      for (int i = 0; i <= len; i++) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(FLAG_BYTE);
    end
  endfunction

  // Hand-built frames: every verdict and line corner case
  task automatic test_directed_frames();
    // noise outside a frame, repeated flags, information frame without BCC2
    line_q = '{8'h00, 8'hFF, 8'h7D, 8'h7E, 8'h7E, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h7E};
    send_line();
    // short frames: one and two header bytes
    line_q = '{8'h7E, 8'hAA, 8'h7E, 8'h7E, 8'hAA, 8'hBB, 8'h7E};
    send_line();
    // bad header check, payload must stay hidden
    line_q = '{8'h7E, 8'h01, 8'h02, 8'h00, 8'h11, 8'h22, 8'h7E};
    send_line();
    // control frame with trailing bytes
    line_q = '{8'h7E, 8'hFF, 8'h01, 8'hFE, 8'h7D, 8'h33, 8'h7E};
    send_line();
    // empty data with zero BCC2: accepted, expected bit flips to 1
    line_q = '{8'h7E, 8'h80, 8'h00, 8'h80, 8'h00, 8'h7E};
    send_line();
    // empty data with nonzero BCC2
    line_q = '{8'h7E, 8'h12, 8'h40, 8'h52, 8'h05, 8'h7E};
    send_line();
    // duplicates: old sequence bit, and control with bit 7 set
    line_q = '{8'h7E, 8'h12, 8'h00, 8'h12, 8'hAA, 8'hBB, 8'h7E,
               8'h7E, 8'h00, 8'hC0, 8'hC0, 8'h7E};
    send_line();
    // stuffed flag, stuffed escape, escaped plain byte
    line_q = '{8'h7E, 8'h00, 8'h40, 8'h40, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7D, 8'h00,
               8'hFF, 8'h00, 8'hDC, 8'h7E};
    send_line();
    // escape still pending at the closing flag
    line_q = '{8'h7E, 8'h00, 8'h00, 8'h00, 8'h11, 8'h7D, 8'h7E};
    send_line();
    // all-ones address and payload
    line_q = '{8'h7E, 8'hFF, 8'h3E, 8'hC1, 8'hFF, 8'hFF, 8'h7E};
    send_line();
  endtask

  // Response check byte under extreme and random own addresses
  task automatic test_own_address();
    logic [7:0] values[3];
    values[0] = 8'hFF;
    values[1] = 8'h00;
    values[2] = 8'($urandom_range(0, 255));
    for (int k = 0; k < 3; k++) begin
      set_own_address(values[k]);
      repeat (5) begin
        random_frame();
        send_line();
      end
    end
  endtask

  // Longest legal frame, then overflow in an information frame, then ordinary frames
  task automatic test_length_limit();
    build_long_frame(HDR_INSEQ, FRAME_LIMIT - 2, 1'b1);
    send_line();
    build_long_frame(HDR_INSEQ, FRAME_LIMIT - 1, 1'b0);
    push_noise(3);
    send_line();
    build_frame(HDR_INSEQ, 4, TAIL_GOOD, 1'b0, 0);
    send_line();
    build_frame(HDR_CTRL, 2, TAIL_GOOD, 1'b0, 0);
    send_line();
  endtask

  // Mostly well-formed frames with random content, mixed with broken ones
  task automatic test_random_traffic();
    int start, mark;
    start = sent_bytes;
    mark  = sent_bytes;
    while (sent_bytes - start < RANDOM_BYTES) begin
      // sender holds off until all results are in, then a new address
      if (sent_bytes - mark >= CFG_INTERVAL) begin
        mark = sent_bytes;
        set_own_address(8'($urandom_range(0, 255)));
      end
      random_frame();
      send_line();
    end
    set_own_address(OWN_ADDR_RESET);
    repeat (10) begin
      random_frame();
      send_line();
    end
  endtask

  // Sequence of tests
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 8'h00;
    rst_n         = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_own_address();
    test_length_limit();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("Run covered %0d line words; results seen: data %0d, accepted %0d, duplicate %0d,",
             sent_bytes, kind_seen[KIND_DATA], kind_seen[KIND_ACCEPT], kind_seen[KIND_DUP]);
    $display("  bcc1 error %0d, bcc2 error %0d, control %0d, overflow %0d; mismatches %0d",
             kind_seen[KIND_BCC1], kind_seen[KIND_BCC2], kind_seen[KIND_CTRL],
             kind_seen[KIND_OVERFLOW], error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/swfr_pkg.sv
sv/swfr_ifs.sv
sv/swfr_core.sv
sv/stop_and_wait_frame_receiver.sv
tb/tb.sv
